>>> sv/lbh_pkg.sv
`timescale 1ns / 1ps
package lbh_pkg;
    localparam int MAX_BINS_DEF      = 512;
    localparam int LOG_FRAC_BITS_DEF = 16;
    localparam int COUNT_WIDTH_DEF   = 32;
    localparam int OBS_FRAC_BITS     = 16;
    localparam int CFG_IDX_W         = 1;

    localparam logic [CFG_IDX_W-1:0] REG_BINS_IN_USE     = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BINS_PER_OCTAVE = 1'd1;

    localparam logic OP_ADD  = 1'b0;
    localparam logic OP_READ = 1'b1;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_RANGE   = 2'd2;

    typedef struct packed {
        logic [8:0]  bin_index;
        logic [31:0] observation;
        logic        op;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [8:0]  bin_index;
        logic [31:0] bin_count;
        logic [31:0] min_seen;
        logic [31:0] max_seen;
        logic [63:0] log_acc;
    } out_item_t;

    // controller -> datapath
    typedef struct packed {
        logic load;      // capture input item, start log unit
        logic log_step;  // advance the squaring unit one phase
        logic bin_calc;  // register bin index from L
        logic mem_read;  // issue counter read
        logic commit;    // write back and form result
        logic clr_step;  // clearing pass write
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic log_done;
        logic is_add;
        logic needs_log;
        logic clr_done;
    } dp_stat_t;
endpackage

>>> sv/lbh_if.sv
`timescale 1ns / 1ps
interface lbh_in_if;
    logic        valid;
    logic        ready;
    logic        op;
    logic [31:0] observation;
    logic [8:0]  bin_select;
    modport source (output valid, op, observation, bin_select, input ready);
    modport sink   (input valid, op, observation, bin_select, output ready);
endinterface

interface lbh_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [8:0]  bin_index;
    logic [31:0] bin_count;
    logic [31:0] min_seen;
    logic [31:0] max_seen;
    logic [63:0] log_acc;
    modport source (output valid, status, bin_index, bin_count, min_seen, max_seen,
                    log_acc, input ready);
    modport sink   (input valid, status, bin_index, bin_count, min_seen, max_seen,
                    log_acc, output ready);
endinterface

interface lbh_cfg_if;
    logic        valid;
    logic        ready;
    logic [0:0]  index;
    logic [31:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> sv/log_binned_histogram.sv
`timescale 1ns / 1ps
// log_binned_histogram: log-spaced histogram of unsigned Q16.16 observations.
// Channels: 'in' takes op/observation/bin_select, 'out' returns one result per
// item (status, bin, count and the running totals), 'cfg' writes bins_in_use
// (index 0) and bins_per_octave (index 1); write cfg only while idle.
// A transaction happens when valid and ready are both high on a rising edge.
// An add runs the log2 unit, which squares the mantissa once per fraction bit
// on a single 32x32 multiplier, then registers the bin, reads the counter and
// commits the result. A read or a zero observation skips the log2 unit and
// goes on to the counter read and commit. One item is processed at a time:
// in.ready is high only while the controller is idle, which it re-enters as
// the result is registered.
// Reset (rst_n, async, low): registers go to 18 / 6, min to all ones, max and
// the log total to zero, and a clearing pass writes zero to each of the
// MAX_BINS counters, one per cycle, with in.ready low; cfg writes are taken
// meanwhile.
// A stalled receiver holds the result in the output register; the next item
// is still accepted and processed, then waits before its write-back until the
// held result is being taken.
module log_binned_histogram #(
    parameter int MAX_BINS      = lbh_pkg::MAX_BINS_DEF,
    parameter int LOG_FRAC_BITS = lbh_pkg::LOG_FRAC_BITS_DEF,
    parameter int COUNT_WIDTH   = lbh_pkg::COUNT_WIDTH_DEF
) (
    input logic clk,
    input logic rst_n,
    lbh_in_if.sink    in,
    lbh_out_if.source out,
    lbh_cfg_if.sink   cfg
);
    import lbh_pkg::*;

    dp_cmd_t   cmd;
    dp_stat_t  stat;
    in_item_t  in_item;
    out_item_t out_item;

    assign cfg.ready = 1'b1;
    assign in_item.op          = in.op;
    assign in_item.observation = in.observation;
    assign in_item.bin_index   = in.bin_select;

    lbh_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in.valid),
        .in_ready  (in.ready),
        .out_valid (out.valid),
        .out_ready (out.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    lbh_dp #(
        .MAX_BINS      (MAX_BINS),
        .LOG_FRAC_BITS (LOG_FRAC_BITS),
        .COUNT_WIDTH   (COUNT_WIDTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .in_item   (in_item),
        .cfg_we    (cfg.valid),
        .cfg_index (cfg.index),
        .cfg_data  (cfg.data),
        .out_item  (out_item)
    );

    assign out.status    = out_item.status;
    assign out.bin_index = out_item.bin_index;
    assign out.bin_count = out_item.bin_count;
    assign out.min_seen  = out_item.min_seen;
    assign out.max_seen  = out_item.max_seen;
    assign out.log_acc   = out_item.log_acc;

`ifndef SYNTHESIS
    a_hold_while_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        (out.valid && !out.ready) |=> (out.valid && $stable(out.bin_count)
        && $stable(out.bin_index) && $stable(out.log_acc)))
        else $error("result changed while stalled");
    a_result_after_commit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> out.valid) else $error("commit gave no result");
    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.log_step, cmd.mem_read, cmd.commit, cmd.clr_step}))
        else $error("conflicting datapath commands");
    a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
        (out.valid && out.max_seen != 32'd0) |-> out.min_seen <= out.max_seen)
        else $error("min above max");
`endif
endmodule

>>> sv/lbh_ram.sv
`timescale 1ns / 1ps
module lbh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

>>> sv/lbh_ctrl.sv
`timescale 1ns / 1ps
module lbh_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  lbh_pkg::dp_stat_t stat,
    output lbh_pkg::dp_cmd_t  cmd
);
    import lbh_pkg::*;

    typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_LOG, S_BIN, S_READ, S_COMMIT} state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    // write-back waits until the output register is free or being taken
    logic out_free;
    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (stat.clr_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_LOG;
                end
            end
            S_LOG:
            begin
                if (stat.needs_log)
                begin
                    cmd.log_step = 1'b1;
                    if (stat.log_done)
                    begin
                        state_next = S_BIN;
                    end
                end
                else
                begin
                    cmd.mem_read = 1'b1;
                    state_next   = S_READ;
                end
            end
            S_BIN:
            begin
                cmd.bin_calc = 1'b1;
                state_next   = S_READ;
            end
            S_READ:
            begin
                cmd.mem_read = 1'b1;
                state_next   = S_COMMIT;
            end
            S_COMMIT:
            begin
                if (out_free)
                begin
                    cmd.commit     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end
endmodule

>>> sv/lbh_dp.sv
`timescale 1ns / 1ps
module lbh_dp #(
    parameter int MAX_BINS      = lbh_pkg::MAX_BINS_DEF,
    parameter int LOG_FRAC_BITS = lbh_pkg::LOG_FRAC_BITS_DEF,
    parameter int COUNT_WIDTH   = lbh_pkg::COUNT_WIDTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  lbh_pkg::dp_cmd_t   cmd,
    output lbh_pkg::dp_stat_t  stat,
    input  lbh_pkg::in_item_t  in_item,
    input  logic               cfg_we,
    input  logic [0:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    output lbh_pkg::out_item_t out_item
);
    import lbh_pkg::*;

    localparam int AW   = $clog2(MAX_BINS);
    localparam int NBW  = $clog2(MAX_BINS + 1);
    localparam int SW   = LOG_FRAC_BITS + 7;          // signed L width
    localparam int PW   = SW + 8;                     // product width
    localparam int FCW  = $clog2(LOG_FRAC_BITS + 1);
    localparam logic [COUNT_WIDTH-1:0] CMAX = '1;

    // configuration
    logic [9:0] bins_in_use_reg;
    logic [6:0] bins_per_octave_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bins_in_use_reg     <= 10'd18;
            bins_per_octave_reg <= 7'd6;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_BINS_IN_USE)
            begin
                bins_in_use_reg <= cfg_data[9:0];
            end
            else if (cfg_index == REG_BINS_PER_OCTAVE)
            begin
                bins_per_octave_reg <= cfg_data[6:0];
            end
        end
    end

    logic [NBW-1:0] nb;
    always_comb
    begin
        if (bins_in_use_reg == 10'd0)
        begin
            nb = NBW'(1);
        end
        else if ({22'd0, bins_in_use_reg} > 32'(MAX_BINS))
        begin
            nb = NBW'(MAX_BINS);
        end
        else
        begin
            nb = NBW'(bins_in_use_reg);
        end
    end

    // captured item
    logic        op_reg;
    logic [31:0] obs_reg;
    logic [8:0]  sel_reg;
    logic [4:0]  e_reg;
    logic [63:0] m_reg;
    logic [LOG_FRAC_BITS-1:0] frac_reg;
    logic [FCW-1:0] step_reg;

    logic [4:0] e_lz;
    always_comb
    begin
        e_lz = 5'd0;
        for (int i = 0; i < 32; i++)
        begin
            if (in_item.observation[i])
            begin
                e_lz = 5'(i);
            end
        end
    end

    // Q1.63 mantissa squared in phases on one 32x32 multiplier:
    // low*low, low*high, high*high, then the partial products are combined
    logic [1:0]  ph_reg;
    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;
    logic [63:0] ll_reg, mid_reg, hh_reg;
    logic [33:0] t_reg;
    logic [63:0] h;
    logic        htop;

    always_comb
    begin
        case (ph_reg)
            2'd0:
            begin
                mul_a = m_reg[31:0];
                mul_b = m_reg[31:0];
            end
            2'd1:
            begin
                mul_a = m_reg[31:0];
                mul_b = m_reg[63:32];
            end
            default:
            begin
                mul_a = m_reg[63:32];
                mul_b = m_reg[63:32];
            end
        endcase
    end
    assign mul_p = mul_a * mul_b;

    // high half of the square; htop is bit 63 of the low half
    assign h    = hh_reg + {31'd0, mid_reg[63:32], 1'b0} + {62'd0, t_reg[33:32]};
    assign htop = t_reg[31];

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= in_item.op;
            obs_reg  <= in_item.observation;
            sel_reg  <= in_item.bin_index;
            e_reg    <= e_lz;
            m_reg    <= {32'd0, in_item.observation} << (6'd63 - {1'b0, e_lz});
            frac_reg <= '0;
        end
        else if (cmd.log_step)
        begin
            case (ph_reg)
                2'd0:
                begin
                    ll_reg <= mul_p;
                end
                2'd1:
                begin
                    mid_reg <= mul_p;
                end
                2'd2:
                begin
                    hh_reg <= mul_p;
                    t_reg  <= {2'b00, ll_reg[63:32]} + {1'b0, mid_reg[31:0], 1'b0};
                end
                default:
                begin
                    frac_reg <= {frac_reg[LOG_FRAC_BITS-2:0], h[63]};
                    m_reg    <= h[63] ? h : {h[62:0], htop};
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            ph_reg   <= '0;
        end
        else if (cmd.load)
        begin
            step_reg <= '0;
            ph_reg   <= '0;
        end
        else if (cmd.log_step)
        begin
            ph_reg <= ph_reg + 2'd1;
            if (ph_reg == 2'd3)
            begin
                step_reg <= step_reg + 1'b1;
            end
        end
    end

    assign stat.log_done  = (step_reg == FCW'(LOG_FRAC_BITS - 1)) && (ph_reg == 2'd3);
    assign stat.is_add    = (op_reg == OP_ADD);
    assign stat.needs_log = (op_reg == OP_ADD) && (obs_reg != 32'd0);

    // L = (e - 16) * 2^F + frac
    logic signed [SW-1:0] l_val;
    assign l_val = {($signed({2'b00, e_reg}) - $signed(7'(OBS_FRAC_BITS))), frac_reg};

    logic signed [PW-1:0] prod;
    assign prod = $signed({1'b0, bins_per_octave_reg}) * l_val;

    // arithmetic shift floors toward minus infinity
    logic signed [PW-1:0] fl;
    logic signed [PW-1:0] bsum;
    assign fl   = prod >>> LOG_FRAC_BITS;
    assign bsum = fl + $signed(PW'({1'b0, nb >> 1}));

    logic [AW-1:0] bin_reg;
    always_ff @(posedge clk)
    begin
        if (cmd.bin_calc)
        begin
            if (bsum < 0)
            begin
                bin_reg <= '0;
            end
            else if (bsum > $signed(PW'(nb) - PW'(1)))
            begin
                bin_reg <= AW'(nb - 1'b1);
            end
            else
            begin
                bin_reg <= AW'(bsum);
            end
        end
    end

    // counter memory, cleared by a sweep after reset
    logic [AW:0]            clr_reg;
    logic                   ram_we;
    logic [AW-1:0]          ram_waddr;
    logic [COUNT_WIDTH-1:0] ram_wdata;
    logic [AW-1:0]          ram_raddr;
    logic [COUNT_WIDTH-1:0] ram_rdata;
    logic                   sel_ok;
    logic                   add_ok;
    logic [COUNT_WIDTH-1:0] cnt_inc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg <= '0;
        end
        else if (cmd.clr_step && !clr_reg[AW])
        begin
            clr_reg <= clr_reg + 1'b1;
        end
    end
    assign stat.clr_done = (clr_reg[AW-1:0] == AW'(MAX_BINS - 1)) || clr_reg[AW];

    assign sel_ok = {23'd0, sel_reg} < 32'(nb);
    assign add_ok = stat.needs_log;
    assign cnt_inc = (ram_rdata == CMAX) ? ram_rdata : ram_rdata + 1'b1;

    assign ram_raddr = stat.is_add ? bin_reg : AW'(sel_reg);
    assign ram_we    = cmd.clr_step || (cmd.commit && add_ok);
    assign ram_waddr = cmd.clr_step ? clr_reg[AW-1:0] : bin_reg;
    assign ram_wdata = cmd.clr_step ? '0 : cnt_inc;

    lbh_ram #(
        .WIDTH (COUNT_WIDTH),
        .DEPTH (MAX_BINS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // totals and result register
    logic [31:0] min_reg, max_reg;
    logic [63:0] sum_reg;
    out_item_t   res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg <= '1;
            max_reg <= '0;
            sum_reg <= '0;
        end
        else if (cmd.commit && add_ok)
        begin
            if (obs_reg < min_reg)
            begin
                min_reg <= obs_reg;
            end
            if (obs_reg > max_reg)
            begin
                max_reg <= obs_reg;
            end
            sum_reg <= sum_reg + 64'(l_val);
        end
    end

    logic [31:0] cnt32;
    always_comb
    begin
        cnt32 = '0;
        for (int i = 0; i < 32; i++)
        begin
            if (i < COUNT_WIDTH)
            begin
                cnt32[i] = (stat.is_add ? cnt_inc[i % COUNT_WIDTH] : ram_rdata[i % COUNT_WIDTH]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            res_reg.min_seen <= (add_ok && obs_reg < min_reg) ? obs_reg : min_reg;
            res_reg.max_seen <= (add_ok && obs_reg > max_reg) ? obs_reg : max_reg;
            res_reg.log_acc  <= add_ok ? sum_reg + 64'(l_val) : sum_reg;
            if (stat.is_add)
            begin
                res_reg.status    <= add_ok ? ST_OK : ST_INVALID;
                res_reg.bin_index <= add_ok ? 9'(bin_reg) : 9'd0;
                res_reg.bin_count <= add_ok ? cnt32 : 32'd0;
            end
            else
            begin
                res_reg.status    <= sel_ok ? ST_OK : ST_RANGE;
                res_reg.bin_index <= sel_reg;
                res_reg.bin_count <= sel_ok ? cnt32 : 32'd0;
            end
        end
    end

    assign out_item = res_reg;
endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps
module tb;
    import lbh_pkg::*;

    typedef struct {
        logic [1:0]  status;
        logic [8:0]  bin_index;
        logic [31:0] bin_count;
        logic [31:0] min_seen;
        logic [31:0] max_seen;
        logic [63:0] log_acc;
    } hist_result_t;

    class hist_scoreboard;
        logic [9:0]  bins_in_use;
        logic [6:0]  bins_per_octave;
        logic [31:0] counts [512];
        logic [31:0] run_min;
        logic [31:0] run_max;
        logic [63:0] log_sum;
        hist_result_t pending[$];
        int errors;
        int adds, reads, invalids, ranges, results;

        function new();
            bins_in_use = 10'd18;
            bins_per_octave = 7'd6;
            foreach (counts[i]) counts[i] = '0;
            run_min = '1;
            run_max = '0;
            log_sum = '0;
            errors = 0;
            adds = 0; reads = 0; invalids = 0; ranges = 0; results = 0;
        endfunction

        function int eff_bins();
            if (bins_in_use < 1) return 1;
            if (bins_in_use > 512) return 512;
            return bins_in_use;
        endfunction

        // floor(log2(x / 2^16) * 2^16) for a Q16.16 x by repeated squaring of a Q1.63 mantissa
        function longint fixed_log2(logic [31:0] x);
            int e;
            logic [63:0] m;
            logic [127:0] sq;
            logic [15:0] frac;
            e = 31;
            while (e > 0 && !x[e]) e--;
            m = 64'(x) << (63 - e);
            frac = '0;
            for (int k = 0; k < 16; k++)
            begin
                sq = 128'(m) * 128'(m);
                frac = {frac[14:0], sq[127]};
                if (sq[127])
                    m = sq[127:64];
                else
                    m = {sq[126:64], sq[63]};
            end
            return longint'(e - 16) * 65536 + longint'(frac);
        endfunction

        function void note_item(logic op, logic [31:0] obs, logic [8:0] sel);
            hist_result_t r;
            longint l, p, b;
            int nb;
            nb = eff_bins();
            r.status = ST_OK;
            r.bin_index = '0;
            r.bin_count = '0;
            if (op == OP_ADD)
            begin
                if (obs == 0)
                begin
                    r.status = ST_INVALID;
                    invalids++;
                end
                else
                begin
                    adds++;
                    l = fixed_log2(obs);
                    p = longint'(bins_per_octave) * l;
                    b = (p >>> 16) + nb / 2;
                    if (b < 0) b = 0;
                    if (b > nb - 1) b = nb - 1;
                    r.bin_index = b[8:0];
                    if (counts[b] != '1) counts[b]++;
                    r.bin_count = counts[b];
                    if (obs < run_min) run_min = obs;
                    if (obs > run_max) run_max = obs;
                    log_sum += l;
                end
            end
            else
            begin
                reads++;
                r.bin_index = sel;
                if (sel >= nb)
                begin
                    r.status = ST_RANGE;
                    ranges++;
                end
                else
                    r.bin_count = counts[sel];
            end
            r.min_seen = run_min;
            r.max_seen = run_max;
            r.log_acc = log_sum;
            pending.push_back(r);
        endfunction

        function void check_result(hist_result_t act);
            hist_result_t e;
            results++;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result status=%0d bin=%0d", $time,
                         act.status, act.bin_index);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (act.status != e.status)
            begin
                $display("%0t: status exp %0d got %0d", $time, e.status, act.status);
                errors++;
            end
            if (act.bin_index != e.bin_index)
            begin
                $display("%0t: bin_index exp %0d got %0d", $time, e.bin_index, act.bin_index);
                errors++;
            end
            if (act.bin_count != e.bin_count)
            begin
                $display("%0t: bin_count exp %0d got %0d", $time, e.bin_count, act.bin_count);
                errors++;
            end
            if (act.min_seen != e.min_seen)
            begin
                $display("%0t: min_seen exp %h got %h", $time, e.min_seen, act.min_seen);
                errors++;
            end
            if (act.max_seen != e.max_seen)
            begin
                $display("%0t: max_seen exp %h got %h", $time, e.max_seen, act.max_seen);
                errors++;
            end
            if (act.log_acc != e.log_acc)
            begin
                $display("%0t: log_acc exp %h got %h", $time, e.log_acc, act.log_acc);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    lbh_in_if  in_ch();
    lbh_out_if out_ch();
    lbh_cfg_if cfg_ch();

    log_binned_histogram dut (
        .clk   (clk),
        .rst_n (rst_n),
        .in    (in_ch.sink),
        .out   (out_ch.source),
        .cfg   (cfg_ch.sink)
    );

    hist_scoreboard sb;
    int stall_mode;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("DONE: errors detected");
        $finish;
    end

    // receiver: stall pattern switches between none, light and heavy
    initial
    begin
        hist_result_t r;
        out_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_ch.valid && out_ch.ready && rst_n)
            begin
                r.status = out_ch.status;
                r.bin_index = out_ch.bin_index;
                r.bin_count = out_ch.bin_count;
                r.min_seen = out_ch.min_seen;
                r.max_seen = out_ch.max_seen;
                r.log_acc = out_ch.log_acc;
                sb.check_result(r);
            end
            if ($urandom_range(0, 63) == 0) stall_mode = $urandom_range(0, 2);
            case (stall_mode)
                0: out_ch.ready <= 1'b1;
                1: out_ch.ready <= ($urandom_range(0, 3) != 0);
                default: out_ch.ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    task automatic write_reg(logic [0:0] idx, logic [31:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        if (idx == REG_BINS_IN_USE)
            sb.bins_in_use = val[9:0];
        else
            sb.bins_per_octave = val[6:0];
    endtask

    task automatic send_item(logic op, logic [31:0] obs, logic [8:0] sel);
        in_ch.valid       <= 1'b1;
        in_ch.op          <= op;
        in_ch.observation <= obs;
        in_ch.bin_select  <= sel;
        do @(posedge clk); while (!in_ch.ready);
        sb.note_item(op, obs, sel);
    endtask

    task automatic pause_sender(int n);
        in_ch.valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    function automatic logic [31:0] rand_obs();
        int sh;
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return 32'h0001_0000;
            2:
            begin
                sh = $urandom_range(0, 31);
                return 32'(1) << sh;
            end
            default:
            begin
                sh = $urandom_range(0, 31);
                return ($urandom >> sh) | 32'd1;
            end
        endcase
    endfunction

    task automatic random_phase(int n);
        int burst;
        logic op;
        logic [8:0] sel;
        while (n > 0)
        begin
            burst = $urandom_range(1, 20);
            while (burst > 0 && n > 0)
            begin
                op = ($urandom_range(0, 3) == 0) ? OP_READ : OP_ADD;
                sel = '0;
                if (op == OP_READ)
                    sel = ($urandom_range(0, 3) == 0) ? 9'($urandom)
                          : 9'($urandom_range(0, sb.eff_bins() - 1));
                send_item(op, ($urandom_range(0, 31) == 0) ? 32'd0 : rand_obs(), sel);
                burst--;
                n--;
            end
            if ($urandom_range(0, 2) != 0) pause_sender($urandom_range(1, 40));
        end
    endtask

    initial
    begin
        int cfg_b [6];
        int cfg_o [6];
        sb = new();
        stall_mode = 0;
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.op = OP_ADD;
        in_ch.observation = '0;
        in_ch.bin_select = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = REG_BINS_IN_USE;
        cfg_ch.data = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, zero observation, range edge, reset config
        send_item(OP_ADD, 32'd0, 9'd0);
        send_item(OP_ADD, 32'd1, 9'd0);
        send_item(OP_ADD, 32'hFFFF_FFFF, 9'd0);
        send_item(OP_ADD, 32'h0001_0000, 9'd0);
        send_item(OP_ADD, 32'h0000_FFFF, 9'd0);
        send_item(OP_ADD, 32'h8000_0000, 9'd0);
        send_item(OP_ADD, 32'hAAAA_5555, 9'd0);
        send_item(OP_ADD, 32'h5555_AAAA, 9'd0);
        send_item(OP_READ, 32'hFFFF_FFFF, 9'd9);
        send_item(OP_READ, 32'd0, 9'd17);
        send_item(OP_READ, 32'd0, 9'd18);
        send_item(OP_READ, 32'd0, 9'h1FF);
        send_item(OP_READ, 32'd0, 9'd0);
        drain();
        // bin count of one and zero bins per octave
        write_reg(REG_BINS_IN_USE, 32'd1);
        write_reg(REG_BINS_PER_OCTAVE, 32'd0);
        send_item(OP_ADD, 32'h0000_0003, 9'd0);
        send_item(OP_READ, 32'd0, 9'd0);
        send_item(OP_READ, 32'd0, 9'd1);
        drain();
        // an out-of-range bins_in_use is clamped by the block; bins_per_octave at its maximum
        write_reg(REG_BINS_IN_USE, 32'h0000_03FF);
        write_reg(REG_BINS_PER_OCTAVE, 32'h0000_007F);
        send_item(OP_ADD, 32'd1, 9'd0);
        send_item(OP_ADD, 32'hFFFF_FFFF, 9'd0);
        send_item(OP_READ, 32'd0, 9'h1FF);
        drain();
        write_reg(REG_BINS_IN_USE, 32'd0);
        send_item(OP_ADD, 32'h0002_0000, 9'd0);
        send_item(OP_READ, 32'd0, 9'd1);
        drain();

        cfg_b = '{18, 512, 2, 1, 100, 37};
        cfg_o = '{6, 64, 1, 0, 17, 3};
        for (int p = 0; p < 6; p++)
        begin
            write_reg(REG_BINS_IN_USE, cfg_b[p]);
            write_reg(REG_BINS_PER_OCTAVE, cfg_o[p]);
            random_phase(255);
            // sender holds off until all results are back
            drain();
        end

        $display("Covered %0d adds, %0d reads, %0d zero observations, %0d range errors,",
                 sb.adds, sb.reads, sb.invalids, sb.ranges);
        $display("%0d results checked over several bin and octave settings.", sb.results);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule

>>> sim.f
sv/lbh_pkg.sv
sv/lbh_if.sv
sv/lbh_ram.sv
sv/lbh_ctrl.sv
sv/lbh_dp.sv
sv/log_binned_histogram.sv
verif/tb.sv
